FILE: rtl/core/tcp_send_ring_buffer_macros.svh
// assertion macros for the send ring buffer
`ifndef TCP_SEND_RING_BUFFER_MACROS_SVH
`define TCP_SEND_RING_BUFFER_MACROS_SVH

`ifndef SYNTHESIS

`define TSRB_ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("send ring buffer check failed");

`define TSRB_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("send ring buffer check failed");

`else

`define TSRB_ASSERT_IMPLIES(label, clk, rst_n, cond, prop)

`define TSRB_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

FILE: rtl/core/tsrb_pkg.sv
// shared types and constants of the send ring buffer
package tsrb_pkg;

    localparam int DEPTH    = 4096;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = 13;
    localparam int LEN_W    = 7;
    localparam int MAX_READ = 64;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_READ,
        OP_REMOVE,
        OP_NOP
    } op_kind_t;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [7:0]       data_byte;
        logic [CNT_W-1:0] offset;
        logic [LEN_W-1:0] read_length;
        logic [CNT_W-1:0] remove_count;
    } in_item_t;

    typedef struct packed {
        logic [7:0]       read_byte;
        logic             byte_valid;
        logic             last;
        logic [CNT_W-1:0] removed;
        logic [CNT_W-1:0] fill_level;
        logic             overflow;
    } out_item_t;

    typedef struct packed {
        op_kind_t         kind;
        logic [7:0]       data_byte;
        logic [CNT_W-1:0] offset;
        logic [LEN_W-1:0] len;
        logic [CNT_W-1:0] count;
    } op_t;

    typedef struct packed {
        logic [CNT_W-1:0] held;
        logic             reading;
    } status_t;

endpackage

FILE: rtl/core/tsrb_front.sv
// front end: accepts items, decodes the command and clamps the read length
module tsrb_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  tsrb_pkg::in_item_t req,
    output logic              op_valid,
    input  logic              op_ready,
    output tsrb_pkg::op_t     op
);

    logic          op_valid_reg;
    logic          op_valid_next;
    tsrb_pkg::op_t op_reg;
    tsrb_pkg::op_t op_next;

    assign req_ready = !op_valid_reg || op_ready;
    assign op_valid  = op_valid_reg;
    assign op        = op_reg;

    always_comb
    begin
        op_next.data_byte = req.data_byte;
        op_next.offset    = req.offset;
        op_next.count     = req.remove_count;
        if (req.read_length > tsrb_pkg::LEN_W'(tsrb_pkg::MAX_READ))
        begin
            op_next.len = tsrb_pkg::LEN_W'(tsrb_pkg::MAX_READ);
        end
        else
        begin
            op_next.len = req.read_length;
        end
        case (req.cmd)
            tsrb_pkg::CMD_WRITE:  op_next.kind = tsrb_pkg::OP_WRITE;
            tsrb_pkg::CMD_READ:   op_next.kind = tsrb_pkg::OP_READ;
            tsrb_pkg::CMD_REMOVE: op_next.kind = tsrb_pkg::OP_REMOVE;
            default:              op_next.kind = tsrb_pkg::OP_NOP;
        endcase
    end

    always_comb
    begin
        op_valid_next = op_valid_reg;
        if (req_valid && req_ready)
        begin
            op_valid_next = 1'b1;
        end
        else if (op_ready)
        begin
            op_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg <= 1'b0;
        end
        else
        begin
            op_valid_reg <= op_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            op_reg <= op_next;
        end
    end

endmodule

FILE: rtl/core/tsrb_queue.sv
// short command queue between front end and engine
module tsrb_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  tsrb_pkg::op_t push_op,
    output logic          pop_valid,
    input  logic          pop_ready,
    output tsrb_pkg::op_t pop_op
);

    tsrb_pkg::op_t                 slots_reg [tsrb_pkg::QDEPTH];
    logic [tsrb_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [tsrb_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [tsrb_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [tsrb_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [tsrb_pkg::QCNT_W-1:0]   count_reg;
    logic [tsrb_pkg::QCNT_W-1:0]   count_next;
    logic                          do_push;
    logic                          do_pop;

    assign push_ready = count_reg != tsrb_pkg::QCNT_W'(tsrb_pkg::QDEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_op     = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == tsrb_pkg::QPTR_W'(tsrb_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + tsrb_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == tsrb_pkg::QPTR_W'(tsrb_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + tsrb_pkg::QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + tsrb_pkg::QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - tsrb_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

FILE: rtl/core/tsrb_engine.sv
// back end: ring state, byte memory and result register
module tsrb_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [tsrb_pkg::CNT_W-1:0]  cfg_data,
    input  logic                        op_valid,
    output logic                        op_ready,
    input  tsrb_pkg::op_t               op,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output tsrb_pkg::out_item_t         rsp,
    output tsrb_pkg::status_t           status
);

    typedef enum logic [1:0] {
        ST_CMD  = 2'b01,
        ST_READ = 2'b10
    } eng_state_t;

    localparam int CW = tsrb_pkg::CNT_W;
    localparam int AW = tsrb_pkg::ADDR_W;
    localparam int LW = tsrb_pkg::LEN_W;

    logic [7:0]          mem [tsrb_pkg::DEPTH];

    eng_state_t          state_reg;
    eng_state_t          state_next;
    logic [CW-1:0]       cap_reg;
    logic [CW-1:0]       cap_next;
    logic [AW-1:0]       wp_reg;
    logic [AW-1:0]       wp_next;
    logic [AW-1:0]       rp_reg;
    logic [AW-1:0]       rp_next;
    logic [CW-1:0]       held_reg;
    logic [CW-1:0]       held_next;
    logic [AW-1:0]       pos_reg;
    logic [AW-1:0]       pos_next;
    logic [LW-1:0]       remain_reg;
    logic [LW-1:0]       remain_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    tsrb_pkg::out_item_t out_meta_reg;
    tsrb_pkg::out_item_t out_meta_next;
    logic [7:0]          byte_q_reg;

    logic                slot_free;
    logic                do_pop;
    logic                emit;
    logic                mem_we;
    logic                mem_re;
    logic [CW-1:0]       cap_eff;
    logic [CW-1:0]       wp_inc;
    logic [CW-1:0]       pos_inc;
    logic [CW-1:0]       avail;
    logic [LW-1:0]       len_c;
    logic [CW:0]         rd_sum;
    logic [CW:0]         rd_start;
    logic [CW-1:0]       rm_cnt;
    logic [CW:0]         rm_sum;
    logic [CW:0]         rm_ptr;

    assign cfg_ready      = 1'b1;
    assign slot_free      = !out_valid_reg || rsp_ready;
    assign op_ready       = (state_reg == ST_CMD) && slot_free;
    assign do_pop         = op_valid && op_ready;
    assign rsp_valid      = out_valid_reg;
    assign status.held    = held_reg;
    assign status.reading = state_reg == ST_READ;

    always_comb
    begin
        rsp = out_meta_reg;
        if (out_meta_reg.byte_valid)
        begin
            rsp.read_byte = byte_q_reg;
        end
    end

    always_comb
    begin
        if (cfg_data == '0)
        begin
            cap_eff = CW'(1);
        end
        else if (cfg_data > CW'(tsrb_pkg::DEPTH))
        begin
            cap_eff = CW'(tsrb_pkg::DEPTH);
        end
        else
        begin
            cap_eff = cfg_data;
        end
    end

    // datapath for each command
    always_comb
    begin
        wp_inc   = CW'(wp_reg) + CW'(1);
        pos_inc  = CW'(pos_reg) + CW'(1);
        avail    = (held_reg > op.offset) ? held_reg - op.offset : '0;
        len_c    = (CW'(op.len) > avail) ? LW'(avail) : op.len;
        rd_sum   = (CW + 1)'(rp_reg) + (CW + 1)'(op.offset);
        rd_start = (rd_sum >= (CW + 1)'(cap_reg)) ? rd_sum - (CW + 1)'(cap_reg) : rd_sum;
        rm_cnt   = (op.count > held_reg) ? held_reg : op.count;
        rm_sum   = (CW + 1)'(rp_reg) + (CW + 1)'(rm_cnt);
        rm_ptr   = (rm_sum >= (CW + 1)'(cap_reg)) ? rm_sum - (CW + 1)'(cap_reg) : rm_sum;
    end

    always_comb
    begin
        state_next     = state_reg;
        cap_next       = cap_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        held_next      = held_reg;
        pos_next       = pos_reg;
        remain_next    = remain_reg;
        emit           = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        out_meta_next  = '0;
        out_meta_next.last       = 1'b1;
        out_meta_next.fill_level = held_reg;

        if (cfg_valid)
        begin
            state_next = ST_CMD;
            cap_next   = cap_eff;
            wp_next    = '0;
            rp_next    = '0;
            held_next  = '0;
        end
        else
        begin
            case (state_reg)
                ST_CMD:
                begin
                    if (do_pop)
                    begin
                        case (op.kind)
                            tsrb_pkg::OP_WRITE:
                            begin
                                emit = 1'b1;
                                if (held_reg >= cap_reg)
                                begin
                                    out_meta_next.overflow = 1'b1;
                                end
                                else
                                begin
                                    mem_we    = 1'b1;
                                    wp_next   = (wp_inc >= cap_reg) ? '0 : AW'(wp_inc);
                                    held_next = held_reg + CW'(1);
                                    out_meta_next.fill_level = held_reg + CW'(1);
                                end
                            end
                            tsrb_pkg::OP_READ:
                            begin
                                if (len_c == '0)
                                begin
                                    emit = 1'b1;
                                end
                                else
                                begin
                                    pos_next    = AW'(rd_start);
                                    remain_next = len_c;
                                    state_next  = ST_READ;
                                end
                            end
                            tsrb_pkg::OP_REMOVE:
                            begin
                                emit      = 1'b1;
                                rp_next   = AW'(rm_ptr);
                                held_next = held_reg - rm_cnt;
                                out_meta_next.removed    = rm_cnt;
                                out_meta_next.fill_level = held_reg - rm_cnt;
                            end
                            default:
                            begin
                                emit = 1'b1;
                            end
                        endcase
                    end
                end
                ST_READ:
                begin
                    if (slot_free)
                    begin
                        emit        = 1'b1;
                        mem_re      = 1'b1;
                        out_meta_next.byte_valid = 1'b1;
                        out_meta_next.last       = remain_reg == LW'(1);
                        pos_next    = (pos_inc >= cap_reg) ? '0 : AW'(pos_inc);
                        remain_next = remain_reg - LW'(1);
                        if (remain_reg == LW'(1))
                        begin
                            state_next = ST_CMD;
                        end
                    end
                end
                default:
                begin
                    state_next = ST_CMD;
                end
            endcase
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CMD;
            cap_reg       <= CW'(tsrb_pkg::DEPTH);
            wp_reg        <= '0;
            rp_reg        <= '0;
            held_reg      <= '0;
            pos_reg       <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            held_reg      <= held_next;
            pos_reg       <= pos_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_meta_reg <= out_meta_next;
        end
    end

    // byte memory, registered read port feeds the result directly
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wp_reg] <= op.data_byte;
        end
        if (mem_re)
        begin
            byte_q_reg <= mem[pos_reg];
        end
    end

endmodule

FILE: rtl/core/tcp_send_ring_buffer.sv
// top level of the send ring buffer: front end, command queue and engine
//
//  port group  | handshake            | carries
//  ------------+----------------------+-------------------------------------
//  req         | req_valid/req_ready  | in_item_t: command and its operands
//  rsp         | rsp_valid/rsp_ready  | out_item_t: one result item
//  cfg         | cfg_valid/cfg_ready  | capacity, 13 bits, empties the ring
//
// write, remove and unused commands are each done in the command state alone
// a read takes a setup step, then returns one byte per cycle while rsp is not stalled (up to 64)
// that rate is set by the single read port of the byte memory
// reset clears pointers, fill count, state and result valid and restores full capacity; the byte memory is not cleared
// a stalled rsp holds the result register; the two-entry queue keeps the front
// end accepting while the engine is busy, until the queue is full
`include "tcp_send_ring_buffer_macros.svh"

module tcp_send_ring_buffer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  tsrb_pkg::in_item_t          req,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output tsrb_pkg::out_item_t         rsp,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [tsrb_pkg::CNT_W-1:0]  cfg_data
);

    logic              fq_valid;
    logic              fq_ready;
    tsrb_pkg::op_t     fq_op;
    logic              qe_valid;
    logic              qe_ready;
    tsrb_pkg::op_t     qe_op;
    tsrb_pkg::status_t status;

    tsrb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .op_valid  (fq_valid),
        .op_ready  (fq_ready),
        .op        (fq_op)
    );

    tsrb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_op    (fq_op),
        .pop_valid  (qe_valid),
        .pop_ready  (qe_ready),
        .pop_op     (qe_op)
    );

    tsrb_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .op_valid  (qe_valid),
        .op_ready  (qe_ready),
        .op        (qe_op),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .status    (status)
    );

    `TSRB_ASSERT_NEXT(a_cfg_empties, clk, rst_n, cfg_valid && cfg_ready, status.held == '0 && !status.reading)
    `TSRB_ASSERT_IMPLIES(a_overflow_shape, clk, rst_n, rsp_valid && rsp.overflow, !rsp.byte_valid && rsp.last && rsp.removed == '0 && rsp.fill_level != '0)
    `TSRB_ASSERT_IMPLIES(a_byte_held, clk, rst_n, rsp_valid && rsp.byte_valid, rsp.fill_level != '0 && rsp.removed == '0 && !rsp.overflow)

endmodule
